>>> src/ptzr_pkg.sv
// ----------------------------------------------------------------------------
// ptzr_pkg: shared types and constants of the PTZ command frame receiver
// Frame positions, relay bit layout, the frame record passed from the parser
// to the relay stage, and the relay update function.
// ----------------------------------------------------------------------------
package ptzr_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	// byte position inside a frame, 0 while hunting for sync
	localparam logic [2:0] POS_HUNT  = 3'd0;
	localparam logic [2:0] POS_ADDR  = 3'd1;
	localparam logic [2:0] POS_CMD1  = 3'd2;
	localparam logic [2:0] POS_CMD2  = 3'd3;
	localparam logic [2:0] POS_DATA1 = 3'd4;
	localparam logic [2:0] POS_DATA2 = 3'd5;
	localparam logic [2:0] POS_CHECK = 3'd6;

	// command two codes
	localparam logic [7:0] CMD_PAN_RIGHT = 8'h02;
	localparam logic [7:0] CMD_PAN_LEFT  = 8'h04;
	localparam logic [7:0] CMD_TILT_UP   = 8'h08;
	localparam logic [7:0] CMD_TILT_DOWN = 8'h10;
	localparam logic [7:0] CMD_ZOOM_IN   = 8'h20;
	localparam logic [7:0] CMD_ZOOM_OUT  = 8'h40;

	// relay latch bit positions
	localparam int RLY_PAN_RIGHT = 0;
	localparam int RLY_PAN_LEFT  = 1;
	localparam int RLY_TILT_UP   = 2;
	localparam int RLY_TILT_DOWN = 3;
	localparam int RLY_ZOOM_IN   = 4;
	localparam int RLY_ZOOM_OUT  = 5;
	localparam int RELAY_COUNT   = 6;

	localparam int QUEUE_DEPTH = 2;

	typedef logic [RELAY_COUNT-1:0] relay_t;

	typedef struct packed {
		logic       sum_ok;
		logic       addr_ok;
		logic [7:0] cmd1;
		logic [7:0] cmd2;
	} frame_t;

	function automatic relay_t apply_commands(relay_t latches, logic [7:0] cmd1,
			logic [7:0] cmd2);
		relay_t r;
		r = latches;
		if (cmd1 == 8'h00 && cmd2 == 8'h00) begin
			r = '0;
		end else begin
			if (cmd2 == CMD_PAN_RIGHT) begin
				r[RLY_PAN_RIGHT] = 1'b1;
				r[RLY_PAN_LEFT]  = 1'b0;
			end
			if (cmd2 == CMD_PAN_LEFT) begin
				r[RLY_PAN_LEFT]  = 1'b1;
				r[RLY_PAN_RIGHT] = 1'b0;
			end
			if (cmd2 == CMD_TILT_UP) begin
				r[RLY_TILT_UP]   = 1'b1;
				r[RLY_TILT_DOWN] = 1'b0;
			end
			if (cmd2 == CMD_TILT_DOWN) begin
				r[RLY_TILT_DOWN] = 1'b1;
				r[RLY_TILT_UP]   = 1'b0;
			end
			if (cmd2 == CMD_ZOOM_IN) begin
				r[RLY_ZOOM_IN]   = 1'b1;
				r[RLY_ZOOM_OUT]  = 1'b0;
			end
			if (cmd2 == CMD_ZOOM_OUT) begin
				r[RLY_ZOOM_OUT]  = 1'b1;
				r[RLY_ZOOM_IN]   = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

>>> src/ptz_command_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// ptz_command_frame_receiver_top: PTZ command frame receiver
// Decodes sync-led seven-byte serial frames and drives six relay latches.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  rx       rx_valid / rx_ready   rx_byte[7:0]
//  cfg      cfg_valid / cfg_ready own_address[7:0]
//  out      out_valid / out_ready checksum_ok, address_match, six relay flags
//
// One byte is taken every cycle while rx_ready is high; a frame result passes
// through the frame queue and the relay stage's output register after its
// checksum byte is taken. The parser only stalls on a checksum byte when the
// frame queue (QueueDepth records) is full; the relay stage drains one record
// a cycle while out_ready is high. Reset clears the parser to sync hunting,
// all relays off and own_address to zero; cfg_ready is always high.
module ptz_command_frame_receiver_top #(
	parameter int QueueDepth = ptzr_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] own_address,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       checksum_ok,
	output logic       address_match,
	output logic       pan_right_on,
	output logic       pan_left_on,
	output logic       tilt_up_on,
	output logic       tilt_down_on,
	output logic       zoom_in_on,
	output logic       zoom_out_on
);

	logic              push;
	logic              push_ready;
	ptzr_pkg::frame_t  push_frame;
	logic              pop_valid;
	logic              pop;
	ptzr_pkg::frame_t  pop_frame;
	ptzr_pkg::relay_t  relays;

	assign cfg_ready = 1'b1;

	ptzr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.own_address(own_address),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_frame (push_frame),
		.push_ready (push_ready)
	);

	ptzr_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_frame (pop_frame),
		.pop       (pop)
	);

	ptzr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (pop_valid),
		.frame        (pop_frame),
		.frame_pop    (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.checksum_ok  (checksum_ok),
		.address_match(address_match),
		.relays       (relays)
	);

	assign pan_right_on = relays[ptzr_pkg::RLY_PAN_RIGHT];
	assign pan_left_on  = relays[ptzr_pkg::RLY_PAN_LEFT];
	assign tilt_up_on   = relays[ptzr_pkg::RLY_TILT_UP];
	assign tilt_down_on = relays[ptzr_pkg::RLY_TILT_DOWN];
	assign zoom_in_on   = relays[ptzr_pkg::RLY_ZOOM_IN];
	assign zoom_out_on  = relays[ptzr_pkg::RLY_ZOOM_OUT];

endmodule

>>> src/ptzr_front.sv
// ----------------------------------------------------------------------------
// ptzr_front: frame parser
// Hunts for sync, collects address and command bytes, keeps the running sum
// and pushes one frame record on each checksum byte.
// ----------------------------------------------------------------------------
module ptzr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [7:0]        own_address,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              push,
	output ptzr_pkg::frame_t  push_frame,
	input  logic              push_ready
);

	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] addr_q;
	logic [7:0] cmd1_q;
	logic [7:0] cmd2_q;
	logic [7:0] own_address_q;
	logic       accept;

	// only the checksum byte needs room in the queue
	assign rx_ready = (pos_q != ptzr_pkg::POS_CHECK) || push_ready;
	assign accept   = rx_valid && rx_ready;
	assign push     = accept && (pos_q == ptzr_pkg::POS_CHECK);

	assign push_frame.sum_ok  = (sum_q == rx_byte);
	assign push_frame.addr_ok = (addr_q == own_address_q);
	assign push_frame.cmd1    = cmd1_q;
	assign push_frame.cmd2    = cmd2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= 8'h00;
		end else if (cfg_valid) begin
			own_address_q <= own_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= ptzr_pkg::POS_HUNT;
		end else if (accept) begin
			unique case (pos_q)
				ptzr_pkg::POS_HUNT: begin
					if (rx_byte == ptzr_pkg::SYNC_BYTE) begin
						pos_q <= ptzr_pkg::POS_ADDR;
					end
				end
				ptzr_pkg::POS_ADDR, ptzr_pkg::POS_CMD1, ptzr_pkg::POS_CMD2,
				ptzr_pkg::POS_DATA1, ptzr_pkg::POS_DATA2: begin
					pos_q <= pos_q + 3'd1;
				end
				default: begin
					pos_q <= ptzr_pkg::POS_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos_q)
				ptzr_pkg::POS_HUNT: begin
					sum_q <= 8'h00;
				end
				ptzr_pkg::POS_ADDR: begin
					addr_q <= rx_byte;
					sum_q  <= sum_q + rx_byte;
				end
				ptzr_pkg::POS_CMD1: begin
					cmd1_q <= rx_byte;
					sum_q  <= sum_q + rx_byte;
				end
				ptzr_pkg::POS_CMD2: begin
					cmd2_q <= rx_byte;
					sum_q  <= sum_q + rx_byte;
				end
				ptzr_pkg::POS_DATA1, ptzr_pkg::POS_DATA2: begin
					sum_q <= sum_q + rx_byte;
				end
				default: begin
					sum_q <= sum_q;
				end
			endcase
		end
	end

endmodule

>>> src/ptzr_queue.sv
// ----------------------------------------------------------------------------
// ptzr_queue: frame record queue
// Small register queue between parser and relay stage, so each side stalls
// on its own.
// ----------------------------------------------------------------------------
module ptzr_queue #(
	parameter int Depth = ptzr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptzr_pkg::frame_t  push_frame,
	output logic              push_ready,
	output logic              pop_valid,
	output ptzr_pkg::frame_t  pop_frame,
	input  logic              pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] Full    = CntW'(Depth);

	ptzr_pkg::frame_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign pop_frame  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

>>> src/ptzr_back.sv
// ----------------------------------------------------------------------------
// ptzr_back: relay stage
// Applies each frame record whose sum and address check out to the relay
// latches and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ptzr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	input  ptzr_pkg::frame_t  frame,
	output logic              frame_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              checksum_ok,
	output logic              address_match,
	output ptzr_pkg::relay_t  relays
);

	ptzr_pkg::relay_t relay_q;
	ptzr_pkg::relay_t relay_next;
	logic             out_valid_q;
	logic             sum_ok_q;
	logic             addr_ok_q;

	// take a new record when the output register is empty or being drained
	assign frame_pop = frame_valid && (!out_valid_q || out_ready);

	always_comb begin
		relay_next = relay_q;
		if (frame.sum_ok && frame.addr_ok) begin
			relay_next = ptzr_pkg::apply_commands(relay_q, frame.cmd1, frame.cmd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_pop) begin
				relay_q     <= relay_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_pop) begin
			sum_ok_q  <= frame.sum_ok;
			addr_ok_q <= frame.addr_ok;
		end
	end

	assign out_valid     = out_valid_q;
	assign checksum_ok   = sum_ok_q;
	assign address_match = addr_ok_q;
	assign relays        = relay_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PTZ command frame receiver
// Feeds serial bytes (noise, well-formed frames, corrupted frames) with random
// gaps on both channels. A frame decoder tracks the parser position, the
// byte sum and the relay latches, and its results are matched in order
// against every item taken from the output channel. Own address changes
// between phases while the block is drained.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 230;
	localparam int PHASES      = 5;
	localparam int SETTLE      = 4;

	typedef struct packed {
		logic             checksum_ok;
		logic             address_match;
		ptzr_pkg::relay_t relays;
	} frame_result_t;

	class frame_checker;
		logic [7:0] own_addr;
		logic [2:0] position;
		logic [7:0] frame_sum;
		logic [7:0] frame_addr;
		logic [7:0] cmd_one;
		logic [7:0] cmd_two;
		ptzr_pkg::relay_t relays;
		frame_result_t expected_frames[$];
		int mismatches;

		function new();
			own_addr   = 8'h00;
			position   = ptzr_pkg::POS_HUNT;
			frame_sum  = 8'h00;
			frame_addr = 8'h00;
			cmd_one    = 8'h00;
			cmd_two    = 8'h00;
			relays     = '0;
			mismatches = 0;
		endfunction

		function void set_address(logic [7:0] a);
			own_addr = a;
		endfunction

		function ptzr_pkg::relay_t update_relays(ptzr_pkg::relay_t cur);
			ptzr_pkg::relay_t r;
			r = cur;
			unique case (cmd_two)
				ptzr_pkg::CMD_PAN_RIGHT: begin
					r[ptzr_pkg::RLY_PAN_RIGHT] = 1'b1;
					r[ptzr_pkg::RLY_PAN_LEFT]  = 1'b0;
				end
				ptzr_pkg::CMD_PAN_LEFT: begin
					r[ptzr_pkg::RLY_PAN_LEFT]  = 1'b1;
					r[ptzr_pkg::RLY_PAN_RIGHT] = 1'b0;
				end
				ptzr_pkg::CMD_TILT_UP: begin
					r[ptzr_pkg::RLY_TILT_UP]   = 1'b1;
					r[ptzr_pkg::RLY_TILT_DOWN] = 1'b0;
				end
				ptzr_pkg::CMD_TILT_DOWN: begin
					r[ptzr_pkg::RLY_TILT_DOWN] = 1'b1;
					r[ptzr_pkg::RLY_TILT_UP]   = 1'b0;
				end
				ptzr_pkg::CMD_ZOOM_IN: begin
					r[ptzr_pkg::RLY_ZOOM_IN]   = 1'b1;
					r[ptzr_pkg::RLY_ZOOM_OUT]  = 1'b0;
				end
				ptzr_pkg::CMD_ZOOM_OUT: begin
					r[ptzr_pkg::RLY_ZOOM_OUT]  = 1'b1;
					r[ptzr_pkg::RLY_ZOOM_IN]   = 1'b0;
				end
				default: begin
				end
			endcase
			if (cmd_one == 8'h00 && cmd_two == 8'h00) r = '0;
			return r;
		endfunction

		// advance the parser by one accepted byte
		function void decode_byte(logic [7:0] b);
			frame_result_t res;
			unique case (position)
				ptzr_pkg::POS_HUNT: begin
					if (b == ptzr_pkg::SYNC_BYTE) begin
						position  = ptzr_pkg::POS_ADDR;
						frame_sum = 8'h00;
					end
				end
				ptzr_pkg::POS_CHECK: begin
					res.checksum_ok   = (frame_sum == b);
					res.address_match = (frame_addr == own_addr);
					if (res.checksum_ok && res.address_match) relays = update_relays(relays);
					res.relays = relays;
					expected_frames.push_back(res);
					position = ptzr_pkg::POS_HUNT;
				end
				default: begin
					if (position == ptzr_pkg::POS_ADDR) frame_addr = b;
					if (position == ptzr_pkg::POS_CMD1) cmd_one = b;
					if (position == ptzr_pkg::POS_CMD2) cmd_two = b;
					frame_sum = frame_sum + b;
					position  = position + 3'd1;
				end
			endcase
		endfunction

		function void compare_bit(string name, logic want, logic got);
			if (want !== got) begin
				$error("%s: expected %0b, actual %0b", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_frame_result(frame_result_t got);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				$error("frame result with no frame pending");
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			compare_bit("checksum_ok", want.checksum_ok, got.checksum_ok);
			compare_bit("address_match", want.address_match, got.address_match);
			compare_bit("pan_right_on", want.relays[ptzr_pkg::RLY_PAN_RIGHT],
				got.relays[ptzr_pkg::RLY_PAN_RIGHT]);
			compare_bit("pan_left_on", want.relays[ptzr_pkg::RLY_PAN_LEFT],
				got.relays[ptzr_pkg::RLY_PAN_LEFT]);
			compare_bit("tilt_up_on", want.relays[ptzr_pkg::RLY_TILT_UP],
				got.relays[ptzr_pkg::RLY_TILT_UP]);
			compare_bit("tilt_down_on", want.relays[ptzr_pkg::RLY_TILT_DOWN],
				got.relays[ptzr_pkg::RLY_TILT_DOWN]);
			compare_bit("zoom_in_on", want.relays[ptzr_pkg::RLY_ZOOM_IN],
				got.relays[ptzr_pkg::RLY_ZOOM_IN]);
			compare_bit("zoom_out_on", want.relays[ptzr_pkg::RLY_ZOOM_OUT],
				got.relays[ptzr_pkg::RLY_ZOOM_OUT]);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] own_address = 8'h00;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       checksum_ok;
	logic       address_match;
	logic       pan_right_on;
	logic       pan_left_on;
	logic       tilt_up_on;
	logic       tilt_down_on;
	logic       zoom_in_on;
	logic       zoom_out_on;

	frame_checker sb;
	int cycle_count = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int frame_bytes = 0;

	ptz_command_frame_receiver_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.own_address  (own_address),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.checksum_ok  (checksum_ok),
		.address_match(address_match),
		.pan_right_on (pan_right_on),
		.pan_left_on  (pan_left_on),
		.tilt_up_on   (tilt_up_on),
		.tilt_down_on (tilt_down_on),
		.zoom_in_on   (zoom_in_on),
		.zoom_out_on  (zoom_out_on)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.checksum_ok   = checksum_ok;
			got.address_match = address_match;
			got.relays = {zoom_out_on, zoom_in_on, tilt_down_on, tilt_up_on,
				pan_left_on, pan_right_on};
			sb.check_frame_result(got);
		end
	end

	// result side: random stalls, with stretches of steady ready
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// hold valid high across back-to-back items; lower it only for a gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		sb.decode_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] d1, input logic [7:0] d2,
			input bit corrupt);
		logic [7:0] sum;
		sum = addr + c1 + c2 + d1 + d2;
		if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(ptzr_pkg::SYNC_BYTE);
		send_byte(addr);
		send_byte(c1);
		send_byte(c2);
		send_byte(d1);
		send_byte(d2);
		send_byte(sum);
		frame_bytes += 7;
	endtask

	task automatic drain_results();
		rx_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_frames.size() != 0);
	endtask

	task automatic write_address(input logic [7:0] a);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_valid   <= 1'b1;
		own_address <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_address(a);
	endtask

	task automatic send_random_frame();
		logic [7:0] addr;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] codes [6];
		int pick;
		codes = '{ptzr_pkg::CMD_PAN_RIGHT, ptzr_pkg::CMD_PAN_LEFT, ptzr_pkg::CMD_TILT_UP,
			ptzr_pkg::CMD_TILT_DOWN, ptzr_pkg::CMD_ZOOM_IN, ptzr_pkg::CMD_ZOOM_OUT};
		if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
		// noise while hunting, never the sync value
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 254)));
		addr = ($urandom_range(0, 9) < 7) ? sb.own_addr : 8'($urandom_range(0, 255));
		c1   = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		if (pick < 6) c2 = codes[pick];
		else if (pick == 6) c2 = 8'h00;
		else c2 = 8'($urandom_range(0, 255));
		send_frame(addr, c1, c2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			$urandom_range(0, 99) < 15);
		if ($urandom_range(0, 39) == 0) drain_results();
	endtask

	initial begin
		logic [7:0] phase_addr;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise, every command, sync value inside a frame, bad sum,
		// foreign address, unknown commands, clear, then the top address
		write_address(8'h00);
		send_byte(8'h00);
		send_byte(8'hFE);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_PAN_RIGHT, 8'hFF, 8'hFF, 1'b0);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_TILT_UP, 8'h00, 8'h00, 1'b0);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_ZOOM_IN, 8'h12, 8'h34, 1'b0);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_PAN_LEFT, 8'hA5, 8'h5A, 1'b0);
		send_frame(8'h00, 8'h01, ptzr_pkg::CMD_TILT_DOWN, 8'h80, 8'h7F, 1'b0);
		send_frame(8'h00, 8'hFF, ptzr_pkg::CMD_ZOOM_OUT, 8'h01, 8'hFE, 1'b0);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_PAN_RIGHT, 8'h00, 8'h00, 1'b1);
		send_frame(8'h5A, 8'h00, ptzr_pkg::CMD_PAN_RIGHT, 8'h00, 8'h00, 1'b0);
		send_frame(8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0);
		send_frame(8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 1'b0);
		send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		write_address(8'hFF);
		send_frame(8'hFF, 8'h00, ptzr_pkg::CMD_TILT_UP, 8'hFF, 8'h00, 1'b0);
		send_frame(8'h00, 8'h00, ptzr_pkg::CMD_ZOOM_IN, 8'h00, 8'hFF, 1'b0);

		// random phases, each under its own address
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				phase_addr = (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
				write_address(phase_addr);
			end
			frame_bytes = 0;
			while (frame_bytes < PHASE_BYTES) send_random_frame();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_frames.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
